@@ hw/rtl/tws_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Timing wheel scheduler package
// Operation codes and sequencer states shared by the scheduler files.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam logic [1:0] OP_ARM      = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam int TAG_BITS  = 9;
    localparam int TYPE_BITS = 8;
    localparam int OUT_ID_BITS = 5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UN_READ,
        ST_UN_SLOT,
        ST_UN_WRITE,
        ST_AP_READ,
        ST_AP_WRITE,
        ST_TK_READ,
        ST_TK_HEAD,
        ST_TK_WALK,
        ST_TK_FLUSH
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/tws_slot_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Timing wheel slot table
// One entry per slot: empty flag, head timer and tail timer of its list.
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tws_slot_ram #(
    parameter int SLOT_BITS = 8,
    parameter int ID_BITS   = 5
) (
    input  wire logic                 clk,
    input  wire logic [SLOT_BITS-1:0] rd_addr,
    output logic                      rd_empty,
    output logic [ID_BITS-1:0]        rd_head,
    output logic [ID_BITS-1:0]        rd_tail,
    input  wire logic                 we,
    input  wire logic [SLOT_BITS-1:0] wr_addr,
    input  wire logic                 wr_empty,
    input  wire logic [ID_BITS-1:0]   wr_head,
    input  wire logic [ID_BITS-1:0]   wr_tail
);
    localparam int SLOTS = 1 << SLOT_BITS;
    localparam int EW    = 1 + 2 * ID_BITS;

    logic [EW-1:0] mem [SLOTS];
    logic [EW-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= {wr_empty, wr_head, wr_tail};
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_empty = rd_reg[EW-1];
    assign rd_head  = rd_reg[2*ID_BITS-1:ID_BITS];
    assign rd_tail  = rd_reg[ID_BITS-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/tws_timer_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Timing wheel timer table
// Per-timer next link, previous link, and slot with tag, in three memories
// with their own write ports; all are read at one shared address.
// ----------------------------------------------------------------------------
module tws_timer_ram #(
    parameter int NUM_TIMERS = 32,
    parameter int ID_BITS    = 5,
    parameter int SLOT_BITS  = 8
) (
    input  wire logic                 clk,
    input  wire logic [ID_BITS-1:0]   rd_addr,
    output logic [ID_BITS-1:0]        rd_next,
    output logic [ID_BITS-1:0]        rd_prev,
    output logic [SLOT_BITS-1:0]      rd_slot,
    output logic [tws_pkg::TAG_BITS-1:0] rd_tag,
    input  wire logic                 next_we,
    input  wire logic [ID_BITS-1:0]   next_waddr,
    input  wire logic [ID_BITS-1:0]   next_wdata,
    input  wire logic                 prev_we,
    input  wire logic [ID_BITS-1:0]   prev_waddr,
    input  wire logic [ID_BITS-1:0]   prev_wdata,
    input  wire logic                 meta_we,
    input  wire logic [ID_BITS-1:0]   meta_waddr,
    input  wire logic [SLOT_BITS-1:0] meta_slot,
    input  wire logic [tws_pkg::TAG_BITS-1:0] meta_tag
);
    import tws_pkg::*;

    localparam int MW = SLOT_BITS + TAG_BITS;

    logic [ID_BITS-1:0] next_mem [NUM_TIMERS];
    logic [ID_BITS-1:0] prev_mem [NUM_TIMERS];
    logic [MW-1:0]      meta_mem [NUM_TIMERS];
    logic [ID_BITS-1:0] next_reg;
    logic [ID_BITS-1:0] prev_reg;
    logic [MW-1:0]      meta_reg;

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= {meta_slot, meta_tag};
        end
        next_reg <= next_mem[rd_addr];
        prev_reg <= prev_mem[rd_addr];
        meta_reg <= meta_mem[rd_addr];
    end

    assign rd_next = next_reg;
    assign rd_prev = prev_reg;
    assign rd_slot = meta_reg[MW-1:TAG_BITS];
    assign rd_tag  = meta_reg[TAG_BITS-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/timing_wheel_scheduler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Timing wheel scheduler
// Single-level hashed timing wheel with doubly linked slot lists in memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot table, one slot per cycle, and
// accepts no transaction until the sweep is done.
// A small sequencer then runs each transaction through memory
// read-modify-write steps with registered reads: an arm of an unlinked timer
// appends it to its slot, an arm of a linked timer first unlinks it, a delete
// of a linked timer only unlinks it, a tick of an empty slot only advances,
// and any other tick clears the slot and walks its list, pausing while the
// output side stalls. A transaction changing nothing is ignored.
// Expiries are reported in insertion order; the block holds back one expiry
// so that the final one of a tick can carry last.
module timing_wheel_scheduler #(
    parameter int SLOT_BITS  = 8,
    parameter int NUM_TIMERS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [4:0]  timer_id,
    input  wire logic [15:0] timeout,
    input  wire logic [7:0]  timer_type,
    input  wire logic        has_handler,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       expired_id,
    output logic [7:0]       expired_type,
    output logic             last
);
    import tws_pkg::*;

    localparam int IDW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [SLOT_BITS-1:0] SLOT_LAST = {SLOT_BITS{1'b1}};

    state_t state_reg, state_next;

    logic [SLOT_BITS-1:0] cur_reg, cur_next;
    logic [SLOT_BITS-1:0] clr_reg, clr_next;
    logic [NUM_TIMERS-1:0] linked_reg, linked_next;
    logic                 arm_reg, arm_next;
    logic [IDW-1:0]       id_reg, id_next;
    logic [SLOT_BITS-1:0] tgt_reg, tgt_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [SLOT_BITS-1:0] un_slot_reg, un_slot_next;
    logic [IDW-1:0]       un_prev_reg, un_prev_next;
    logic [IDW-1:0]       un_nxt_reg, un_nxt_next;
    logic [IDW-1:0]       walk_reg, walk_next;
    logic [IDW-1:0]       wtail_reg, wtail_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDW-1:0]       pend_id_reg, pend_id_next;
    logic [TYPE_BITS-1:0] pend_type_reg, pend_type_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDW-1:0]       out_id_reg, out_id_next;
    logic [TYPE_BITS-1:0] out_type_reg, out_type_next;
    logic                 out_last_reg, out_last_next;

    // Memory ports.
    logic [SLOT_BITS-1:0] s_rd_addr;
    logic                 s_rd_empty;
    logic [IDW-1:0]       s_rd_head, s_rd_tail;
    logic                 s_we;
    logic [SLOT_BITS-1:0] s_wr_addr;
    logic                 s_wr_empty;
    logic [IDW-1:0]       s_wr_head, s_wr_tail;

    logic [IDW-1:0]       t_rd_addr;
    logic [IDW-1:0]       t_rd_next, t_rd_prev;
    logic [SLOT_BITS-1:0] t_rd_slot;
    logic [TAG_BITS-1:0]  t_rd_tag;
    logic                 nx_we, pv_we, mt_we;
    logic [IDW-1:0]       nx_waddr, nx_wdata, pv_waddr, pv_wdata, mt_waddr;

    logic                 accept;
    logic [IDW-1:0]       in_id;
    logic                 id_ok;
    logic                 is_head, is_tail;
    logic                 out_free;
    logic                 walk_stall;

    tws_slot_ram #(
        .SLOT_BITS (SLOT_BITS),
        .ID_BITS   (IDW)
    ) u_slot_ram (
        .clk      (clk),
        .rd_addr  (s_rd_addr),
        .rd_empty (s_rd_empty),
        .rd_head  (s_rd_head),
        .rd_tail  (s_rd_tail),
        .we       (s_we),
        .wr_addr  (s_wr_addr),
        .wr_empty (s_wr_empty),
        .wr_head  (s_wr_head),
        .wr_tail  (s_wr_tail)
    );

    tws_timer_ram #(
        .NUM_TIMERS (NUM_TIMERS),
        .ID_BITS    (IDW),
        .SLOT_BITS  (SLOT_BITS)
    ) u_timer_ram (
        .clk        (clk),
        .rd_addr    (t_rd_addr),
        .rd_next    (t_rd_next),
        .rd_prev    (t_rd_prev),
        .rd_slot    (t_rd_slot),
        .rd_tag     (t_rd_tag),
        .next_we    (nx_we),
        .next_waddr (nx_waddr),
        .next_wdata (nx_wdata),
        .prev_we    (pv_we),
        .prev_waddr (pv_waddr),
        .prev_wdata (pv_wdata),
        .meta_we    (mt_we),
        .meta_waddr (mt_waddr),
        .meta_slot  (tgt_reg),
        .meta_tag   (tag_reg)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_id    = IDW'(timer_id);
    assign id_ok    = (32'(timer_id) < 32'(NUM_TIMERS));
    assign is_head  = (s_rd_head == id_reg);
    assign is_tail  = (s_rd_tail == id_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign walk_stall = t_rd_tag[TAG_BITS-1] && pend_valid_reg && !out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SLOT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (op == OP_ARM && id_ok && timeout != 16'd0)
                    begin
                        state_next = linked_reg[in_id] ? ST_UN_READ : ST_AP_READ;
                    end
                    else if (op == OP_DELETE && id_ok && linked_reg[in_id])
                    begin
                        state_next = ST_UN_READ;
                    end
                    else if (op == OP_TICK)
                    begin
                        state_next = ST_TK_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_UN_READ:  state_next = ST_UN_SLOT;
            ST_UN_SLOT:  state_next = ST_UN_WRITE;
            ST_UN_WRITE: state_next = arm_reg ? ST_AP_READ : ST_IDLE;
            ST_AP_READ:  state_next = ST_AP_WRITE;
            ST_AP_WRITE: state_next = ST_IDLE;
            ST_TK_READ:  state_next = ST_TK_HEAD;
            ST_TK_HEAD:  state_next = s_rd_empty ? ST_IDLE : ST_TK_WALK;
            ST_TK_WALK:
            begin
                if (!walk_stall && walk_reg == wtail_reg)
                begin
                    state_next = ST_TK_FLUSH;
                end
            end
            ST_TK_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory commands and datapath register updates.
    always_comb
    begin
        cur_next        = cur_reg;
        clr_next        = clr_reg;
        linked_next     = linked_reg;
        arm_next        = arm_reg;
        id_next         = id_reg;
        tgt_next        = tgt_reg;
        tag_next        = tag_reg;
        un_slot_next    = un_slot_reg;
        un_prev_next    = un_prev_reg;
        un_nxt_next     = un_nxt_reg;
        walk_next       = walk_reg;
        wtail_next      = wtail_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_type_next  = pend_type_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_id_next     = out_id_reg;
        out_type_next   = out_type_reg;
        out_last_next   = out_last_reg;

        s_rd_addr  = cur_reg;
        s_we       = 1'b0;
        s_wr_addr  = cur_reg;
        s_wr_empty = 1'b1;
        s_wr_head  = '0;
        s_wr_tail  = '0;
        t_rd_addr  = id_reg;
        nx_we      = 1'b0;
        nx_waddr   = un_prev_reg;
        nx_wdata   = un_nxt_reg;
        pv_we      = 1'b0;
        pv_waddr   = un_nxt_reg;
        pv_wdata   = un_prev_reg;
        mt_we      = 1'b0;
        mt_waddr   = id_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                s_we      = 1'b1;
                s_wr_addr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    id_next  = in_id;
                    arm_next = (op == OP_ARM);
                    tgt_next = cur_reg + SLOT_BITS'(timeout);
                    tag_next = {has_handler, timer_type};
                end
            end
            ST_UN_READ:
            begin
                t_rd_addr = id_reg;
            end
            ST_UN_SLOT:
            begin
                s_rd_addr    = t_rd_slot;
                un_slot_next = t_rd_slot;
                un_prev_next = t_rd_prev;
                un_nxt_next  = t_rd_next;
            end
            ST_UN_WRITE:
            begin
                // Links of the list ends are stale, so head and tail decide.
                s_we       = 1'b1;
                s_wr_addr  = un_slot_reg;
                s_wr_empty = is_head && is_tail;
                s_wr_head  = is_head ? un_nxt_reg : s_rd_head;
                s_wr_tail  = is_tail ? un_prev_reg : s_rd_tail;
                nx_we      = !is_head;
                pv_we      = !is_tail;
                linked_next[id_reg] = 1'b0;
            end
            ST_AP_READ:
            begin
                s_rd_addr = tgt_reg;
            end
            ST_AP_WRITE:
            begin
                s_we       = 1'b1;
                s_wr_addr  = tgt_reg;
                s_wr_empty = 1'b0;
                s_wr_head  = s_rd_empty ? id_reg : s_rd_head;
                s_wr_tail  = id_reg;
                nx_we      = !s_rd_empty;
                nx_waddr   = s_rd_tail;
                nx_wdata   = id_reg;
                pv_we      = 1'b1;
                pv_waddr   = id_reg;
                pv_wdata   = s_rd_tail;
                mt_we      = 1'b1;
                mt_waddr   = id_reg;
                linked_next[id_reg] = 1'b1;
            end
            ST_TK_READ:
            begin
                s_rd_addr = cur_reg;
            end
            ST_TK_HEAD:
            begin
                if (s_rd_empty)
                begin
                    cur_next = cur_reg + 1'b1;
                end
                else
                begin
                    s_we       = 1'b1;
                    s_wr_addr  = cur_reg;
                    t_rd_addr  = s_rd_head;
                    walk_next  = s_rd_head;
                    wtail_next = s_rd_tail;
                end
            end
            ST_TK_WALK:
            begin
                if (walk_stall)
                begin
                    t_rd_addr = walk_reg;
                end
                else
                begin
                    linked_next[walk_reg] = 1'b0;
                    t_rd_addr = t_rd_next;
                    walk_next = t_rd_next;
                    if (t_rd_tag[TAG_BITS-1])
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_id_next    = pend_id_reg;
                            out_type_next  = pend_type_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = walk_reg;
                        pend_type_next  = t_rd_tag[TYPE_BITS-1:0];
                    end
                end
            end
            ST_TK_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    cur_next = cur_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = pend_id_reg;
                    out_type_next   = pend_type_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    cur_next        = cur_reg + 1'b1;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cur_reg        <= '0;
            clr_reg        <= '0;
            linked_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            clr_reg        <= clr_next;
            linked_reg     <= linked_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arm_reg       <= arm_next;
        id_reg        <= id_next;
        tgt_reg       <= tgt_next;
        tag_reg       <= tag_next;
        un_slot_reg   <= un_slot_next;
        un_prev_reg   <= un_prev_next;
        un_nxt_reg    <= un_nxt_next;
        walk_reg      <= walk_next;
        wtail_reg     <= wtail_next;
        pend_id_reg   <= pend_id_next;
        pend_type_reg <= pend_type_next;
        out_id_reg    <= out_id_next;
        out_type_reg  <= out_type_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign expired_id   = OUT_ID_BITS'(out_id_reg);
    assign expired_type = out_type_reg;
    assign last         = out_last_reg;

endmodule
`default_nettype wire
